FILE: hdl/esfd_pkg.sv
// ----------------------------------------------------------------------------
// esfd_pkg: shared types and constants of the serial frame decoder
// Parser phases, the window scanner's states and status, protocol constants.
// ----------------------------------------------------------------------------
package esfd_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PROTOCOL = 2'd0;
	localparam logic [1:0] CFG_FORMAT   = 2'd1;
	localparam logic [1:0] CFG_CHANNELS = 2'd2;

	localparam int CFG_DATA_W = 7;

	// Protocol versions and sample formats.
	localparam logic [1:0] VER_LEGACY = 2'd0;
	localparam logic [1:0] VER_SYNC   = 2'd1;
	localparam logic       FMT_24BIT  = 1'b0;
	localparam logic       FMT_16BIT  = 1'b1;

	// Frame constants.
	localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
	localparam logic [3:0]  HEADER_HIGH   = 4'hF;
	localparam logic [15:0] V0_OFFSET     = 16'd4160;
	localparam logic [15:0] UV_SCALE      = 16'd18750;
	localparam int          HEADERS       = 16;

	// Result kinds.
	localparam logic KIND_SAMPLE    = 1'b0;
	localparam logic KIND_LOCK_LOST = 1'b1;

	localparam int CHAN_W  = 6;
	localparam int VALUE_W = 39;

	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_COUNT   = 6'b000010,
		PH_HEADER  = 6'b000100,
		PH_MAGIC   = 6'b001000,
		PH_SAMPLE  = 6'b010000,
		PH_LEADOFF = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		HS_IDLE = 2'b01,
		HS_SCAN = 2'b10
	} hunt_state_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic match;
	} hunt_stat_t;

endpackage

FILE: hdl/esfd_ram.sv
// ----------------------------------------------------------------------------
// esfd_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module esfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/esfd_hunt.sv
// ----------------------------------------------------------------------------
// esfd_hunt: version-2 frame lock search
// Keeps recent bytes in a circular RAM; after each byte, once it holds sixteen
// frames, reads the sixteen header positions one per cycle and compares them.
// ----------------------------------------------------------------------------
module esfd_hunt #(
	parameter int DEPTH = 4096,
	parameter int STR_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                push,
	input  logic [7:0]          rx_byte,
	input  logic [STR_W-1:0]    stride,
	output esfd_pkg::hunt_stat_t stat
);

	import esfd_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(DEPTH + 1);
	localparam int LEN_W = STR_W + 4;
	localparam int CW    = ((LEN_W > FW) ? LEN_W : FW) + 2;

	hunt_state_t    state_q;
	logic [AW-1:0]  pos_q;
	logic [FW-1:0]  fill_q;
	logic [AW-1:0]  addr_q;
	logic [4:0]     k_q;
	logic           ok_q;
	logic           rd_valid_s1;
	logic [3:0]     k_s1;

	logic [LEN_W-1:0] len;
	logic [AW-1:0]    pos_next;
	logic [FW-1:0]    fill_next;
	logic [CW-1:0]    base_full;
	logic [CW-1:0]    step_full;
	logic [AW-1:0]    base_addr;
	logic [AW-1:0]    step_addr;
	logic             start_scan;
	logic             issue;
	logic             hit;
	logic [7:0]       rd_data;

	assign len = {stride, 4'b0000};

	always_comb begin
		pos_next  = (pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
		fill_next = (fill_q == FW'(DEPTH)) ? fill_q : fill_q + 1'b1;
		start_scan = push && (CW'(len) <= CW'(DEPTH)) && (CW'(fill_next) >= CW'(len));

		// Oldest header sits len bytes behind the next write position.
		base_full = CW'(pos_next) + CW'(DEPTH) - CW'(len);
		if (base_full >= CW'(DEPTH)) begin
			base_full = base_full - CW'(DEPTH);
		end
		base_addr = base_full[AW-1:0];

		step_full = CW'(addr_q) + CW'(stride);
		if (step_full >= CW'(DEPTH)) begin
			step_full = step_full - CW'(DEPTH);
		end
		step_addr = step_full[AW-1:0];
	end

	assign issue = (state_q == HS_SCAN) && !k_q[4];
	assign hit   = (rd_data == {HEADER_HIGH, k_s1});

	esfd_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_window (
		.clk   (clk),
		.we    (push),
		.waddr (pos_q),
		.wdata (rx_byte),
		.re    (issue),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= HS_IDLE;
			pos_q       <= '0;
			fill_q      <= '0;
			k_q         <= '0;
			ok_q        <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else if (clear) begin
			state_q     <= HS_IDLE;
			pos_q       <= '0;
			fill_q      <= '0;
			k_q         <= '0;
			ok_q        <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			unique case (state_q)
				HS_IDLE: begin
					if (push) begin
						pos_q  <= pos_next;
						fill_q <= fill_next;
					end
					if (start_scan) begin
						state_q <= HS_SCAN;
						k_q     <= '0;
						ok_q    <= 1'b1;
					end
				end
				HS_SCAN: begin
					if (issue) begin
						k_q <= k_q + 1'b1;
					end
					if (rd_valid_s1 && !hit) begin
						ok_q <= 1'b0;
					end
					if (rd_valid_s1 && (k_s1 == 4'(HEADERS - 1))) begin
						state_q <= HS_IDLE;
					end
				end
				default: state_q <= HS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k_q[3:0];
		if (state_q == HS_IDLE) begin
			addr_q <= base_addr;
		end else if (issue) begin
			addr_q <= step_addr;
		end
	end

	assign stat.busy  = (state_q == HS_SCAN);
	assign stat.done  = (state_q == HS_SCAN) && rd_valid_s1 && (k_s1 == 4'(HEADERS - 1));
	assign stat.match = ok_q && hit;

endmodule

FILE: hdl/eeg_serial_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// eeg_serial_frame_decoder_unit: multichannel amplifier byte stream deframer
// Finds frame sync, decodes channel samples to microvolts in Q16 and reports
// loss of version-2 header lock.
//
//  port group   | direction | item contents
//  s_axis_*     | in        | tdata[7:0] rx_byte
//  m_axis_*     | out       | tdata: channel, value_q16; tuser: kind; tlast: last
//  cfg_*        | in        | write enable, register index, register data
//
// Most bytes are taken one per cycle. In version 2, while hunting for lock and
// once the byte window holds sixteen frames, the input stalls after each byte
// while the header scan reads the window RAM one position per cycle via its single
// read port. Reset needs no clearing pass; a fill count marks the valid part of
// the window. The input stalls while a result waits and the output is not taken.
// ----------------------------------------------------------------------------
module eeg_serial_frame_decoder_unit #(
	parameter int MAX_CHANNELS = 64,
	parameter int HUNT_DEPTH   = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // [7:0] rx_byte
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [47:0]                        m_axis_tdata,  // [5:0] channel, [44:6] value_q16
	output logic                               m_axis_tuser,  // [0] kind
	output logic                               m_axis_tlast,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [esfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import esfd_pkg::*;

	localparam int STRIDE_MAX = 4 + 3 * MAX_CHANNELS + (MAX_CHANNELS + 7) / 8;
	localparam int STR_W      = $clog2(STRIDE_MAX + 1);
	localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// Configuration.
	logic [1:0] version_q;
	logic       format_q;
	logic [6:0] channels_q;

	// Parser state.
	phase_t            phase_q;
	logic [3:0]        frame_cnt_q;
	logic [CH_W-1:0]   chan_idx_q;
	logic [1:0]        byte_cnt_q;
	logic [3:0]        leadoff_q;
	logic [23:0]       partial_q;

	// Output register.
	logic              out_valid_q;
	logic              out_kind_q;
	logic [CHAN_W-1:0] out_chan_q;
	logic [VALUE_W-1:0] out_value_q;
	logic              out_last_q;

	logic              accept;
	logic              cfg_hit;
	logic              is_v2;
	logic              is_v0;
	logic [6:0]        eff_ch;
	logic [7:0]        ch_sum;
	logic [3:0]        leadoff_n;
	logic [1:0]        bytes_per_ch;
	logic [STR_W-1:0]  stride;
	logic [23:0]       partial_next;
	logic [1:0]        byte_cnt_next;
	logic              sample_done;
	logic              frame_last;
	logic              hdr_bad;
	logic              emit;
	logic              emit_kind;
	logic [CHAN_W-1:0] emit_chan;
	logic [VALUE_W-1:0] emit_value;
	logic              emit_last;
	logic [15:0]       v0_count;
	logic signed [23:0] raw;
	logic signed [39:0] product;
	logic [CH_W+CHAN_W-1:0] chan_ext;
	logic              hunt_push;
	logic              hunt_clear;
	hunt_stat_t        hunt_stat;

	assign is_v2   = version_q[1];
	assign is_v0   = (version_q == VER_LEGACY);
	assign cfg_hit = cfg_we && (cfg_index inside {CFG_PROTOCOL, CFG_FORMAT, CFG_CHANNELS});

	assign s_axis_tready = !hunt_stat.busy && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Frame geometry from the configuration.
	always_comb begin
		eff_ch = channels_q;
		if (eff_ch == 7'd0) begin
			eff_ch = 7'd1;
		end
		if (eff_ch > 7'(MAX_CHANNELS)) begin
			eff_ch = 7'(MAX_CHANNELS);
		end
		ch_sum    = {1'b0, eff_ch} + 8'd7;
		leadoff_n = (ch_sum[6:3] < 4'd2) ? 4'd2 : ch_sum[6:3];
		bytes_per_ch = (is_v0 || format_q == FMT_16BIT) ? 2'd2 : 2'd3;
		stride = STR_W'(2) + STR_W'(leadoff_n) + STR_W'(eff_ch) + STR_W'(eff_ch)
			+ ((bytes_per_ch == 2'd3) ? STR_W'(eff_ch) : '0);
	end

	// Sample assembly and scaling.
	always_comb begin
		partial_next  = {partial_q[15:0], s_axis_tdata};
		byte_cnt_next = byte_cnt_q + 1'b1;
		sample_done   = (byte_cnt_next >= bytes_per_ch);
		frame_last    = (8'(chan_idx_q) + 8'd1) >= {1'b0, eff_ch};
		hdr_bad       = (s_axis_tdata != {HEADER_HIGH, frame_cnt_q});

		// Legacy count: (b0 - 64) * 64 + (b1 - 64).
		v0_count = {2'b00, partial_next[15:8], 6'b000000} + {8'h00, partial_next[7:0]}
			- V0_OFFSET;
		raw = (format_q == FMT_24BIT) ? $signed(partial_next)
			: $signed({partial_next[15:0], 8'h00});
		product = raw * $signed({1'b0, UV_SCALE[14:0]});
		chan_ext = {{CHAN_W{1'b0}}, chan_idx_q};

		emit       = 1'b0;
		emit_kind  = KIND_SAMPLE;
		emit_chan  = chan_ext[CHAN_W-1:0];
		emit_value = is_v0 ? {{7{v0_count[15]}}, v0_count, 16'h0000}
			: product[VALUE_W-1:0];
		emit_last  = frame_last;
		if (accept && phase_q == PH_HEADER && hdr_bad) begin
			emit       = 1'b1;
			emit_kind  = KIND_LOCK_LOST;
			emit_chan  = '0;
			emit_value = '0;
			emit_last  = 1'b0;
		end else if (accept && phase_q == PH_SAMPLE && sample_done) begin
			emit = 1'b1;
		end
	end

	assign hunt_push  = accept && (phase_q == PH_HUNT) && is_v2;
	assign hunt_clear = cfg_hit || (accept && phase_q == PH_HEADER && hdr_bad);

	esfd_hunt #(
		.DEPTH (HUNT_DEPTH),
		.STR_W (STR_W)
	) u_hunt (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (hunt_clear),
		.push    (hunt_push),
		.rx_byte (s_axis_tdata),
		.stride  (stride),
		.stat    (hunt_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q   <= VER_SYNC;
			format_q    <= FMT_16BIT;
			channels_q  <= 7'd16;
			phase_q     <= PH_HUNT;
			frame_cnt_q <= '0;
			chan_idx_q  <= '0;
			byte_cnt_q  <= '0;
			leadoff_q   <= '0;
			partial_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_hit) begin
				unique case (cfg_index)
					CFG_PROTOCOL: version_q  <= cfg_data[1:0];
					CFG_FORMAT:   format_q   <= cfg_data[0];
					CFG_CHANNELS: channels_q <= cfg_data[6:0];
					default: ;
				endcase
				phase_q     <= PH_HUNT;
				frame_cnt_q <= '0;
				chan_idx_q  <= '0;
				byte_cnt_q  <= '0;
				leadoff_q   <= '0;
				partial_q   <= '0;
			end else if (hunt_stat.done) begin
				if (hunt_stat.match) begin
					frame_cnt_q <= '0;
					phase_q     <= PH_HEADER;
				end
			end else if (accept) begin
				unique case (phase_q) inside
					PH_HUNT: begin
						if (!is_v2 && s_axis_tdata == SYNC_BYTE) begin
							phase_q <= PH_COUNT;
						end
					end
					PH_COUNT, PH_MAGIC: begin
						phase_q    <= PH_SAMPLE;
						chan_idx_q <= '0;
						byte_cnt_q <= '0;
						partial_q  <= '0;
					end
					PH_HEADER: begin
						frame_cnt_q <= hdr_bad ? 4'd0 : frame_cnt_q + 1'b1;
						phase_q     <= hdr_bad ? PH_HUNT : PH_MAGIC;
					end
					PH_SAMPLE: begin
						if (!sample_done) begin
							partial_q  <= partial_next;
							byte_cnt_q <= byte_cnt_next;
						end else begin
							partial_q  <= '0;
							byte_cnt_q <= '0;
							if (frame_last) begin
								chan_idx_q <= '0;
								if (is_v0) begin
									phase_q <= PH_HUNT;
								end else begin
									leadoff_q <= leadoff_n;
									phase_q   <= PH_LEADOFF;
								end
							end else begin
								chan_idx_q <= chan_idx_q + 1'b1;
							end
						end
					end
					PH_LEADOFF: begin
						if (leadoff_q <= 4'd1) begin
							leadoff_q <= '0;
							phase_q   <= is_v2 ? PH_HEADER : PH_HUNT;
						end else begin
							leadoff_q <= leadoff_q - 1'b1;
						end
					end
					default: phase_q <= PH_HUNT;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q  <= emit_kind;
			out_chan_q  <= emit_chan;
			out_value_q <= emit_value;
			out_last_q  <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_value_q, out_chan_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule
